@@ sv/searchable_deque_engine_unit_assert.svh @@
// Assertion macros used by the deque engine controller.
`ifndef SEARCHABLE_DEQUE_ENGINE_UNIT_ASSERT_SVH
`define SEARCHABLE_DEQUE_ENGINE_UNIT_ASSERT_SVH
// Implication checked at each rising edge outside reset.
`define SDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked at each rising edge outside reset.
`define SDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ sv/sde_pkg.sv @@
package sde_pkg;
	localparam int unsigned DefCapacity = 64;

	typedef enum logic [3:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_EXISTS     = 4'd4,
		OP_REM_FIRST  = 4'd5,
		OP_REM_ALL    = 4'd6,
		OP_CLEAR      = 4'd7,
		OP_READ       = 4'd8
	} op_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_END,
		S_END_RD,
		S_FRONT_WAIT,
		S_BACK_WAIT,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture op and value
		logic exec;       // perform an end operation, clear or read
		logic scan_start; // reset scan pointers
		logic scan_read;  // issue memory read at read pointer
		logic scan_step;  // consume read data, maybe copy it down
		logic scan_end;   // commit count after a removal scan
		logic rd_front;   // issue read of the front slot
		logic rd_back;    // latch front data, issue read of the back slot
		logic fin;        // latch back data into result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_op;    // captured op is a search or removal
		logic scan_last;  // read pointer has reached the count
		logic stop_early; // exists has matched
	} stat_t;
endpackage

@@ sv/searchable_deque_engine_unit.sv @@
// Channel | Handshake            | Payload
// in      | in_valid / in_ready   | op, value
// out     | out_valid / out_ready | front_value, back_value, count, found, status
// An end operation, clear or read goes through S_EXEC, S_END_RD, S_FRONT_WAIT
// and S_BACK_WAIT before out_valid rises. Exists and removals walk the stored
// entries one by one through the single read port of the slot memory.
// Reset empties the store at once; no clearing pass is needed.
// The next request is taken only after the previous result has been accepted,
// so the unit holds one request at a time.
module searchable_deque_engine_unit #(
	parameter int unsigned CAPACITY = sde_pkg::DefCapacity
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         op,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [6:0]         count,
	output logic               found,
	output logic [1:0]         status
);
	import sde_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	cmd_t  cmd;
	stat_t stat;
	logic [CW-1:0] cnt;

	sde_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
	);

	sde_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd, .stat, .op, .value, .front_value, .back_value,
		.count(cnt), .found, .status
	);

	assign count = 7'(cnt);
endmodule

@@ sv/sde_datapath.sv @@
module sde_datapath #(
	parameter int unsigned CAPACITY = sde_pkg::DefCapacity,
	parameter int unsigned IW = $clog2(CAPACITY),
	parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sde_pkg::cmd_t      cmd,
	output sde_pkg::stat_t     stat,
	input  logic [3:0]         op,
	input  logic signed [31:0] value,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [CW-1:0]      count,
	output logic               found,
	output logic [1:0]         status
);
	import sde_pkg::*;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata_q;
	logic [IW-1:0] raddr;
	logic          re;
	logic [IW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;

	logic [3:0]    op_q;
	logic [31:0]   val_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic          hit_q;
	logic [1:0]    st_q;
	logic [31:0]   front_q;

	localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

	function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW + 1)'(h) + (CW + 1)'(k);
		if (s >= (CW + 1)'(CAPACITY)) s = s - (CW + 1)'(CAPACITY);
		return s[IW-1:0];
	endfunction

	logic full, empty, match;
	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign match = (rdata_q == val_q);
	assign stat.scan_op = (op_q == OP_EXISTS) || (op_q == OP_REM_FIRST) ||
		(op_q == OP_REM_ALL);
	assign stat.scan_last = (rd_q == cnt_q);
	assign stat.stop_early = hit_q && (op_q == OP_EXISTS);

	logic drop;
	assign drop = match && (op_q != OP_EXISTS) && !(op_q == OP_REM_FIRST && hit_q);

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = val_q;
		re = 1'b0;
		raddr = slot(head_q, rd_q);
		if (cmd.exec && op_q == OP_PUSH_FRONT && !full) begin
			we = 1'b1;
			waddr = (head_q == '0) ? LastIdx : head_q - IW'(1);
		end else if (cmd.exec && op_q == OP_PUSH_BACK && !full) begin
			we = 1'b1;
			waddr = slot(head_q, cnt_q);
		end else if (cmd.scan_step && op_q != OP_EXISTS && !drop && wr_q != rd_q) begin
			we = 1'b1;
			waddr = slot(head_q, wr_q);
			wdata = rdata_q;
		end
		if (cmd.scan_read) re = 1'b1;
		if (cmd.rd_front) begin
			re = 1'b1;
			raddr = head_q;
		end
		if (cmd.rd_back) begin
			re = 1'b1;
			raddr = slot(head_q, cnt_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			hit_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			if (cmd.load) begin
				st_q <= ST_OK;
				hit_q <= 1'b0;
			end
			if (cmd.exec) begin
				unique case (op_q)
					OP_PUSH_FRONT: begin
						if (full) st_q <= ST_FULL;
						else begin
							head_q <= (head_q == '0) ? LastIdx : head_q - IW'(1);
							cnt_q <= cnt_q + CW'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (full) st_q <= ST_FULL;
						else cnt_q <= cnt_q + CW'(1);
					end
					OP_POP_FRONT: begin
						if (empty) st_q <= ST_EMPTY;
						else begin
							head_q <= (head_q == LastIdx) ? '0 : head_q + IW'(1);
							cnt_q <= cnt_q - CW'(1);
						end
					end
					OP_POP_BACK: begin
						if (empty) st_q <= ST_EMPTY;
						else cnt_q <= cnt_q - CW'(1);
					end
					OP_CLEAR: begin
						cnt_q <= '0;
						head_q <= '0;
					end
					default: begin
						if (empty) st_q <= ST_EMPTY;
					end
				endcase
			end
			if (cmd.scan_start) begin
				rd_q <= '0;
				wr_q <= '0;
			end
			if (cmd.scan_step) begin
				rd_q <= rd_q + CW'(1);
				if (match && !(op_q == OP_REM_FIRST && hit_q)) hit_q <= 1'b1;
				if (!drop) wr_q <= wr_q + CW'(1);
			end
			if (cmd.scan_end) begin
				if (op_q != OP_EXISTS) begin
					cnt_q <= wr_q;
					if (!hit_q) st_q <= ST_NOTFOUND;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			val_q <= value;
		end
		if (cmd.rd_back) front_q <= rdata_q;
		if (cmd.fin) begin
			front_value <= empty ? '0 : front_q;
			back_value <= empty ? '0 : rdata_q;
			count <= cnt_q;
			found <= hit_q;
			status <= st_q;
		end
	end
endmodule

@@ sv/sde_ctrl.sv @@
`include "searchable_deque_engine_unit_assert.svh"
module sde_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output sde_pkg::cmd_t  cmd,
	input  sde_pkg::stat_t stat
);
	import sde_pkg::*;

	state_t state_q, state_d;
	logic   ov_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:       if (in_valid) state_d = S_EXEC;
			S_EXEC:       state_d = stat.scan_op ? S_SCAN_RD : S_END_RD;
			S_SCAN_RD:    state_d = stat.scan_last ? S_SCAN_END : S_SCAN_CHK;
			S_SCAN_CHK:   state_d = S_SCAN_RD;
			S_SCAN_END:   state_d = S_END_RD;
			S_END_RD:     state_d = S_FRONT_WAIT;
			S_FRONT_WAIT: state_d = S_BACK_WAIT;
			S_BACK_WAIT:  state_d = S_DONE;
			S_DONE:       if (!ov_q || out_ready) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
		if (state_q == S_SCAN_RD && stat.stop_early) state_d = S_SCAN_END;
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE:       cmd.load = in_valid;
			S_EXEC: begin
				if (!stat.scan_op) cmd.exec = 1'b1;
				cmd.scan_start = 1'b1;
			end
			S_SCAN_RD:    cmd.scan_read = !stat.scan_last && !stat.stop_early;
			S_SCAN_CHK:   cmd.scan_step = 1'b1;
			S_SCAN_END:   cmd.scan_end = 1'b1;
			S_END_RD:     cmd.rd_front = 1'b1;
			S_FRONT_WAIT: cmd.rd_back = 1'b1;
			S_BACK_WAIT:  cmd.fin = 1'b1;
			S_DONE:       ;
			default:      ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ready) ov_q <= 1'b0;
			if (state_q == S_BACK_WAIT) ov_q <= 1'b1;
		end
	end
	assign out_valid = ov_q;

	`SDE_ASSERT_IMP(a_one_busy, clk, arst_n, in_ready && in_valid, state_q == S_IDLE)
	`SDE_ASSERT_NXT(a_fin_valid, clk, arst_n, cmd.fin, ov_q)
	`SDE_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.fin, !ov_q || out_ready)
endmodule
